### src/slpe_pkg.sv
// shared types, register indexes, mode codes and color constants
// for the status LED pattern engine; no dependencies
package slpe_pkg;

  // time base and scan counter
  localparam int TIME_W = 32;
  localparam int CNT_W  = $clog2(TIME_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd3;

  // pattern modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_SOLID   = 3'd1;
  localparam logic [2:0] MODE_SLOW    = 3'd2;
  localparam logic [2:0] MODE_FAST    = 3'd3;
  localparam logic [2:0] MODE_RAINBOW = 3'd4;
  localparam logic [2:0] MODE_SOS     = 3'd5;

  // register reset values
  localparam logic [2:0]  MODE_RST   = MODE_OFF;
  localparam logic [7:0]  BRIGHT_RST = 8'd32;
  localparam logic [15:0] SLOW_RST   = 16'd1000;
  localparam logic [15:0] FAST_RST   = 16'd200;

  // sos sequence
  localparam int         SOS_W     = 5;
  localparam logic [4:0] SOS_LAST  = 5'd17;
  localparam logic [4:0] SOS_STEPS = 5'd18;

  // hue arithmetic
  localparam logic [4:0] HUE_DIV    = 5'd12;
  localparam logic [8:0] HUE_MOD    = 9'd255;
  localparam logic [7:0] HUE_SECTOR = 8'd43;
  localparam logic [7:0] RAINBOW_V  = 8'd200;

  // scaler length, one brightness bit per cycle
  localparam int         SCALE_W    = 4;
  localparam logic [3:0] SCALE_LAST = 4'd8;

  // pixel, red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam rgb_t COLOR_BLACK = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
  localparam rgb_t COLOR_SOLID = '{blue: 8'd255, green: 8'd80,  red: 8'd0};
  localparam rgb_t COLOR_SLOW  = '{blue: 8'd160, green: 8'd180, red: 8'd0};
  localparam rgb_t COLOR_FAST  = '{blue: 8'd0,   green: 8'd140, red: 8'd255};
  localparam rgb_t COLOR_SOS   = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};

  // controller states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DEC   = 6'b000100,
    ST_HSV1  = 6'b001000,
    ST_HSV2  = 6'b010000,
    ST_SCALE = 6'b100000
  } state_t;

  // sos on/off interval per step, the final step is the long pause
  function automatic logic [15:0] sos_interval(input logic [SOS_W-1:0] idx);
    logic [15:0] iv;
    case (idx)
      5'd5, 5'd6, 5'd8, 5'd10, 5'd11: iv = 16'd450;
      SOS_LAST:                       iv = 16'd1000;
      default:                        iv = 16'd150;
    endcase
    return iv;
  endfunction

endpackage

### src/status_led_pattern_engine_core.sv
// top level of the status LED pattern engine: controller, serial time pass,
// rainbow color wheel and output register; uses slpe_pkg and slpe_scale
//
// Each transfer on the in_ channel carries a millisecond timestamp; depending
// on the pattern mode it yields zero or one pixel on the out_ channel, each
// channel scaled by brightness as (c * brightness) >> 8. The timestamp is
// processed one bit per cycle: a serial pass computes the wrapped elapsed
// time since the last toggle, compares it with the active period and divides
// the time by 12 modulo 255 for the rainbow hue. An item that gives no pixel
// goes through the pass, the decision and back to idle before the next
// transfer; an item with a pixel also goes through the bit-serial brightness
// scaler and its hand-off to the output register and, in rainbow mode,
// through the color-wheel states HSV1 and HSV2 before the scaler.
// A full output register that is not drained stalls the hand-off.
// A finished pixel sits in the output register, so the next timestamp may
// be taken while it waits. Writing a new mode clears the toggle time, lit
// flag and SOS step; the user must write configuration while the block is
// idle, the block itself does not enforce it.
module status_led_pattern_engine_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [31:0] now_ms
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,
  // out_tdata: [7:0] red, [15:8] green, [23:16] blue
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,
  input  logic                             cfg_we,
  input  logic [slpe_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [slpe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TW = slpe_pkg::TIME_W;

  // configuration
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  bri_r, bri_nxt;
  logic [15:0] slow_r, slow_nxt;
  logic [15:0] fast_r, fast_nxt;

  // pattern state
  logic [TW-1:0]              last_r, last_nxt;
  logic                       lit_r, lit_nxt;
  logic [slpe_pkg::SOS_W-1:0] step_r, step_nxt;

  // controller
  slpe_pkg::state_t           state_r, state_nxt;
  logic [slpe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // serial time pass
  logic [TW-1:0] now_sh_r, now_sh_nxt;
  logic [TW-1:0] div_sh_r, div_sh_nxt;
  logic [15:0]   per_sh_r, per_sh_nxt;
  logic          borrow_r, borrow_nxt;
  logic          ge_r, ge_nxt;
  logic [3:0]    rem12_r, rem12_nxt;
  logic [7:0]    hue_r, hue_nxt;

  // color wheel
  logic [2:0] region_r, region_nxt;
  logic [7:0] hrem_r, hrem_nxt;

  // scaler and output
  slpe_pkg::rgb_t rgb_r, rgb_nxt;
  slpe_pkg::rgb_t sc_rgb;
  logic           sc_load, sc_done;
  logic           out_valid_r, out_valid_nxt;
  slpe_pkg::rgb_t out_rgb_r, out_rgb_nxt;

  // combinational helpers
  logic [slpe_pkg::SOS_W-1:0] sos_idx;
  logic                       ea, eb, ed;
  logic [4:0]                 r5;
  logic                       qbit;
  logic [8:0]                 a9;
  logic [7:0]                 hbase;
  logic [7:0]                 hdiff;
  logic [8:0]                 qa, ta;
  logic [16:0]                qp, tp;
  logic [7:0]                 wq, wt;
  logic                       out_free;

  assign sos_idx  = (step_r < slpe_pkg::SOS_STEPS) ? step_r : '0;
  assign out_free = !out_valid_r || out_tready;

  // elapsed = now - last, serial subtract LSB first, compared against period
  assign ea = now_sh_r[0];
  assign eb = last_r[0];
  assign ed = ea ^ eb ^ borrow_r;

  // division by 12 MSB first, quotient folded modulo 255
  assign r5   = {rem12_r, div_sh_r[TW-1]};
  assign qbit = (r5 >= slpe_pkg::HUE_DIV);
  assign a9   = {hue_r, qbit};

  // hue sector and offset within it
  always_comb begin
    if (hue_r >= 8'd215) begin
      region_nxt = 3'd5;
      hbase      = 8'd215;
    end else if (hue_r >= 8'd172) begin
      region_nxt = 3'd4;
      hbase      = 8'd172;
    end else if (hue_r >= 8'd129) begin
      region_nxt = 3'd3;
      hbase      = 8'd129;
    end else if (hue_r >= 8'd86) begin
      region_nxt = 3'd2;
      hbase      = 8'd86;
    end else if (hue_r >= slpe_pkg::HUE_SECTOR) begin
      region_nxt = 3'd1;
      hbase      = slpe_pkg::HUE_SECTOR;
    end else begin
      region_nxt = 3'd0;
      hbase      = 8'd0;
    end
    hdiff    = hue_r - hbase;
    hrem_nxt = 8'(hdiff * 8'd6);
  end

  // with full saturation: q = v*(256-rem)>>8 (255 at rem 0), t = v*(rem+1)>>8
  assign qa = (hrem_r == 8'd0) ? 9'd255 : (9'd256 - {1'b0, hrem_r});
  assign ta = {1'b0, hrem_r} + 9'd1;
  assign qp = 17'(qa) * 17'(slpe_pkg::RAINBOW_V);
  assign tp = 17'(ta) * 17'(slpe_pkg::RAINBOW_V);
  assign wq = qp[15:8];
  assign wt = tp[15:8];

  // controller, pattern state and configuration
  always_comb begin
    mode_nxt      = mode_r;
    bri_nxt       = bri_r;
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    last_nxt      = last_r;
    lit_nxt       = lit_r;
    step_nxt      = step_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    now_sh_nxt    = now_sh_r;
    div_sh_nxt    = div_sh_r;
    per_sh_nxt    = per_sh_r;
    borrow_nxt    = borrow_r;
    ge_nxt        = ge_r;
    rem12_nxt     = rem12_r;
    hue_nxt       = hue_r;
    rgb_nxt       = rgb_r;
    sc_load       = 1'b0;
    out_valid_nxt = out_valid_r;
    out_rgb_nxt   = out_rgb_r;

    // output register drains on transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      slpe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          now_sh_nxt = in_tdata;
          div_sh_nxt = in_tdata;
          case (mode_r)
            slpe_pkg::MODE_SLOW: per_sh_nxt = slow_r;
            slpe_pkg::MODE_FAST: per_sh_nxt = fast_r;
            slpe_pkg::MODE_SOS:  per_sh_nxt = slpe_pkg::sos_interval(sos_idx);
            default:             per_sh_nxt = '0;
          endcase
          borrow_nxt = 1'b0;
          ge_nxt     = 1'b1;
          rem12_nxt  = '0;
          hue_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = slpe_pkg::ST_SCAN;
        end
      end

      slpe_pkg::ST_SCAN: begin
        // elapsed bit against period bit, later bits decide
        borrow_nxt = (~ea & eb) | (~(ea ^ eb) & borrow_r);
        if (ed != per_sh_r[0]) begin
          ge_nxt = ed;
        end
        now_sh_nxt = {ea, now_sh_r[TW-1:1]};
        last_nxt   = {eb, last_r[TW-1:1]};
        per_sh_nxt = {1'b0, per_sh_r[15:1]};
        // hue quotient bit
        rem12_nxt  = qbit ? 4'(r5 - slpe_pkg::HUE_DIV) : r5[3:0];
        hue_nxt    = (a9 >= slpe_pkg::HUE_MOD) ? 8'(a9 - slpe_pkg::HUE_MOD) : a9[7:0];
        div_sh_nxt = {div_sh_r[TW-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == slpe_pkg::CNT_W'(TW - 1)) begin
          state_nxt = slpe_pkg::ST_DEC;
        end
      end

      slpe_pkg::ST_DEC: begin
        // shift registers are back in place, now_sh_r holds the timestamp
        state_nxt = slpe_pkg::ST_IDLE;
        case (mode_r)
          slpe_pkg::MODE_SOLID: begin
            lit_nxt   = 1'b1;
            rgb_nxt   = slpe_pkg::COLOR_SOLID;
            sc_load   = 1'b1;
            state_nxt = slpe_pkg::ST_SCALE;
          end
          slpe_pkg::MODE_SLOW, slpe_pkg::MODE_FAST: begin
            if (ge_r) begin
              lit_nxt  = !lit_r;
              last_nxt = now_sh_r;
              if (lit_r) begin
                rgb_nxt = slpe_pkg::COLOR_BLACK;
              end else if (mode_r == slpe_pkg::MODE_SLOW) begin
                rgb_nxt = slpe_pkg::COLOR_SLOW;
              end else begin
                rgb_nxt = slpe_pkg::COLOR_FAST;
              end
              sc_load   = 1'b1;
              state_nxt = slpe_pkg::ST_SCALE;
            end
          end
          slpe_pkg::MODE_RAINBOW: begin
            lit_nxt   = 1'b1;
            state_nxt = slpe_pkg::ST_HSV1;
          end
          slpe_pkg::MODE_SOS: begin
            if (ge_r) begin
              lit_nxt   = !sos_idx[0];
              step_nxt  = (sos_idx == slpe_pkg::SOS_LAST) ? '0 : sos_idx + 1'b1;
              last_nxt  = now_sh_r;
              rgb_nxt   = sos_idx[0] ? slpe_pkg::COLOR_BLACK : slpe_pkg::COLOR_SOS;
              sc_load   = 1'b1;
              state_nxt = slpe_pkg::ST_SCALE;
            end
          end
          default: begin
            // off, and the unused codes
            if (lit_r) begin
              lit_nxt   = 1'b0;
              rgb_nxt   = slpe_pkg::COLOR_BLACK;
              sc_load   = 1'b1;
              state_nxt = slpe_pkg::ST_SCALE;
            end
          end
        endcase
      end

      slpe_pkg::ST_HSV1: begin
        state_nxt = slpe_pkg::ST_HSV2;
      end

      slpe_pkg::ST_HSV2: begin
        // value 200, p is zero at full saturation
        case (region_r)
          3'd0:    rgb_nxt = '{blue: 8'd0, green: wt, red: slpe_pkg::RAINBOW_V};
          3'd1:    rgb_nxt = '{blue: 8'd0, green: slpe_pkg::RAINBOW_V, red: wq};
          3'd2:    rgb_nxt = '{blue: wt, green: slpe_pkg::RAINBOW_V, red: 8'd0};
          3'd3:    rgb_nxt = '{blue: slpe_pkg::RAINBOW_V, green: wq, red: 8'd0};
          3'd4:    rgb_nxt = '{blue: slpe_pkg::RAINBOW_V, green: 8'd0, red: wt};
          default: rgb_nxt = '{blue: wq, green: 8'd0, red: slpe_pkg::RAINBOW_V};
        endcase
        sc_load   = 1'b1;
        state_nxt = slpe_pkg::ST_SCALE;
      end

      slpe_pkg::ST_SCALE: begin
        if (sc_done && out_free) begin
          out_valid_nxt = 1'b1;
          out_rgb_nxt   = sc_rgb;
          state_nxt     = slpe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = slpe_pkg::ST_IDLE;
      end
    endcase

    // register writes
    if (cfg_we) begin
      case (cfg_addr)
        slpe_pkg::REG_MODE: begin
          if (cfg_wdata[2:0] != mode_r) begin
            mode_nxt = cfg_wdata[2:0];
            last_nxt = '0;
            lit_nxt  = 1'b0;
            step_nxt = '0;
          end
        end
        slpe_pkg::REG_BRIGHT: bri_nxt  = cfg_wdata[7:0];
        slpe_pkg::REG_SLOW:   slow_nxt = cfg_wdata;
        slpe_pkg::REG_FAST:   fast_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= slpe_pkg::MODE_RST;
      bri_r       <= slpe_pkg::BRIGHT_RST;
      slow_r      <= slpe_pkg::SLOW_RST;
      fast_r      <= slpe_pkg::FAST_RST;
      last_r      <= '0;
      lit_r       <= 1'b0;
      step_r      <= '0;
      state_r     <= slpe_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      bri_r       <= bri_nxt;
      slow_r      <= slow_nxt;
      fast_r      <= fast_nxt;
      last_r      <= last_nxt;
      lit_r       <= lit_nxt;
      step_r      <= step_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    now_sh_r  <= now_sh_nxt;
    div_sh_r  <= div_sh_nxt;
    per_sh_r  <= per_sh_nxt;
    borrow_r  <= borrow_nxt;
    ge_r      <= ge_nxt;
    rem12_r   <= rem12_nxt;
    hue_r     <= hue_nxt;
    region_r  <= region_nxt;
    hrem_r    <= hrem_nxt;
    rgb_r     <= rgb_nxt;
    out_rgb_r <= out_rgb_nxt;
  end

  // brightness scaler
  slpe_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (sc_load),
    .bri     (bri_r),
    .rgb_in  (rgb_nxt),
    .done    (sc_done),
    .rgb_out (sc_rgb)
  );

  assign in_tready  = (state_r == slpe_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rgb_r;

endmodule

### src/slpe_scale.sv
// bit-serial brightness scaler for the three color channels
// computes (c * brightness) >> 8 one brightness bit per cycle; uses slpe_pkg
module slpe_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic [7:0]     bri,
  input  slpe_pkg::rgb_t rgb_in,
  output logic           done,
  output slpe_pkg::rgb_t rgb_out
);

  logic [15:0]                  cand_r [3];
  logic [15:0]                  cand_nxt [3];
  logic [15:0]                  prod_r [3];
  logic [15:0]                  prod_nxt [3];
  logic [7:0]                   bsh_r, bsh_nxt;
  logic [slpe_pkg::SCALE_W-1:0] cnt_r, cnt_nxt;

  assign done = (cnt_r == slpe_pkg::SCALE_LAST);

  // shift-add step, all three lanes share the brightness bit
  always_comb begin
    bsh_nxt = bsh_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < 3; i++) begin
      cand_nxt[i] = cand_r[i];
      prod_nxt[i] = prod_r[i];
    end
    if (load) begin
      cand_nxt[0] = {8'd0, rgb_in.red};
      cand_nxt[1] = {8'd0, rgb_in.green};
      cand_nxt[2] = {8'd0, rgb_in.blue};
      for (int i = 0; i < 3; i++) begin
        prod_nxt[i] = '0;
      end
      bsh_nxt = bri;
      cnt_nxt = '0;
    end else if (!done) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[i] = prod_r[i] + (bsh_r[0] ? cand_r[i] : 16'd0);
        cand_nxt[i] = {cand_r[i][14:0], 1'b0};
      end
      bsh_nxt = {1'b0, bsh_r[7:1]};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // counter is control, lanes are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bsh_r <= bsh_nxt;
    for (int i = 0; i < 3; i++) begin
      cand_r[i] <= cand_nxt[i];
      prod_r[i] <= prod_nxt[i];
    end
  end

  assign rgb_out.red   = prod_r[0][15:8];
  assign rgb_out.green = prod_r[1][15:8];
  assign rgb_out.blue  = prod_r[2][15:8];

endmodule

### src/slpe_checker.sv
// port-level checks for status_led_pattern_engine_core
// bound to the top level; no package dependencies
module slpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled pixel stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled pixel changed or dropped");

  // one timestamp at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again during the time pass");

  // the serial pass cannot produce a pixel in the cycle after a transfer
  a_no_early_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("pixel appeared too early after input transfer");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind status_led_pattern_engine_core slpe_checker u_slpe_checker (.*);
